### hdl/sck3_pkg.sv
// Shared constants, types and the per-channel sharpen function for the cross sharpen block.
`default_nettype none

package sck3_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int FW_W      = 11;
	localparam int ROW_W     = 16;
	localparam int EW        = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = ROW_W'(480);
	localparam logic [EW-1:0]    MAX_WIDTH_E      = EW'(MAX_WIDTH);

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// control carried alongside an item while its line data is read
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             res;
		logic             last;
		logic             top_ctr;
		logic             left_ctr;
		logic             right_ok;
		logic             drain;
		logic [PIX_W-1:0] px;
	} s1_ctl_t;

	// 5*c - t - l - r - b, clamped to 0..255
	function automatic logic [CH_W-1:0] sharpen_chan(
		input logic [CH_W-1:0] t,
		input logic [CH_W-1:0] l,
		input logic [CH_W-1:0] c,
		input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] b
	);
		logic [CH_W+2:0] pos;
		logic [CH_W+1:0] neg;
		logic [CH_W+2:0] diff;
		pos  = (CH_W+3)'({c, 2'b00}) + (CH_W+3)'(c);
		neg  = (CH_W+2)'(t) + (CH_W+2)'(l) + (CH_W+2)'(r) + (CH_W+2)'(b);
		diff = pos - (CH_W+3)'(neg);
		if (pos < (CH_W+3)'(neg)) begin
			return '0;
		end else if (diff > (CH_W+3)'(255)) begin
			return '1;
		end else begin
			return diff[CH_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

### hdl/sharpen_cross_kernel_3x3.sv
// Top level: 3x3 cross-kernel sharpen of an RGB raster stream with two line buffers.
//
// Input stream (s_*): one pixel per item, tuser = 0, or a drain item, tuser = 1, that
// carries no pixel. Output stream (m_*): sharpened pixels in raster order, one row
// behind the input; tlast marks the last pixel of the frame. Drain items push out the
// final row, one pixel per drain item; the item with tlast returns all counters to the
// start of a new frame. Pixels of the first row give no output; a pixel that arrives
// while the last row waits for drains is dropped, as is a drain when nothing waits.
// Configuration: cfg_index 0 = frame width (1..1024), 1 = frame height (1..65535),
// written while the stream is idle.
// Throughput: one item per cycle while s_tready is high. Each item reads its column of
// the line memory and the next column of the middle-row copy in the cycle it is taken,
// so the memory read port sets that figure. A result passes the memory read register,
// loaded at the edge that takes the item, and then the output register.
// Reset: counters clear, width 640 and height 480; line contents stay undefined until
// written, so no clearing pass is needed. When the receiver stalls, the output register
// holds its result and the read stage keeps taking items until it holds one with a
// result; after that s_tready falls until the output moves.
`default_nettype none

module sharpen_cross_kernel_3x3 import sck3_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
	input  wire logic                  s_tuser,   // mode
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
	output      logic                  m_tlast,   // frame_end
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic             pending_q;

	logic [EW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [EW-1:0]    col_inc;
	logic             col_wrap;
	logic             ocol_wrap;
	logic             orow_end;
	logic [ROW_W-1:0] row_inc;
	logic             is_drain;
	logic             acc;
	logic             live;
	logic             emit_c;
	logic             last_c;

	s1_ctl_t          s1_q;
	logic             s1_valid_q;
	logic             s1_adv;

	// line_mem holds {upper, middle}; right_mem is a copy of middle read one column ahead
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0]   right_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_rd_s1;
	logic [PIX_W-1:0]   right_rd_s1;
	logic [COL_W-1:0]   rd_a;
	logic [COL_W-1:0]   rd_b;
	logic               mem_we;
	logic [2*PIX_W-1:0] wr_line;
	logic [PIX_W-1:0]   wr_mid;
	logic               fwd_line_s1;
	logic               fwd_right_s1;
	logic [2*PIX_W-1:0] fwd_line_d_s1;
	logic [PIX_W-1:0]   fwd_right_d_s1;

	logic [2*PIX_W-1:0] line_s1;
	logic [PIX_W-1:0]   upper_s1;
	logic [PIX_W-1:0]   ctr_s1;
	logic [PIX_W-1:0]   right_raw_s1;
	logic [PIX_W-1:0]   top_s1;
	logic [PIX_W-1:0]   left_s1;
	logic [PIX_W-1:0]   right_s1;
	logic [PIX_W-1:0]   bot_s1;
	logic [PIX_W-1:0]   res_s1;
	logic [PIX_W-1:0]   left_q;

	logic               out_valid_q;
	logic [PIX_W-1:0]   out_data_q;
	logic               out_last_q;
	logic               out_load;

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(frame_width_q) > MAX_WIDTH_E) begin
			w_eff = MAX_WIDTH_E;
		end else begin
			w_eff = EW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;
	end

	assign col_inc   = EW'(in_col_q) + EW'(1);
	assign col_wrap  = col_inc >= w_eff;
	assign ocol_wrap = (EW'(out_col_q) + EW'(1)) >= w_eff;
	assign orow_end  = ({1'b0, out_row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
	assign row_inc   = in_row_q + ROW_W'(1);

	assign is_drain = (s_tuser == MODE_DRAIN);
	assign acc      = s_tvalid && s_tready;
	assign live     = is_drain ? pending_q : !pending_q;
	assign emit_c   = live && (is_drain || (in_row_q != '0));
	assign last_c   = emit_c && orow_end && ocol_wrap;

	// handshake: the read stage moves on unless its result is blocked by a full output
	assign s1_adv   = !s1_valid_q || !s1_q.res || !out_valid_q || m_tready;
	assign s_tready = s1_adv;
	assign out_load = s1_valid_q && s1_q.res && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// frame counters, updated as each item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= 1'b0;
		end else if (acc && live) begin
			if (last_c) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pending_q <= 1'b0;
			end else begin
				if (emit_c) begin
					if (ocol_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
				in_col_q <= col_wrap ? '0 : col_inc[COL_W-1:0];
				if (!is_drain && col_wrap) begin
					in_row_q <= row_inc;
					if (row_inc >= h_eff || row_inc == '0) begin
						pending_q <= 1'b1;
					end
				end
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			s1_q         <= '0;
			fwd_line_s1  <= 1'b0;
			fwd_right_s1 <= 1'b0;
		end else if (acc) begin
			s1_valid_q    <= live;
			s1_q.col      <= in_col_q;
			s1_q.res      <= emit_c;
			s1_q.last     <= last_c;
			s1_q.top_ctr  <= (out_row_q == '0);
			s1_q.left_ctr <= (in_col_q == '0);
			s1_q.right_ok <= !col_wrap;
			s1_q.drain    <= is_drain;
			s1_q.px       <= s_tdata;
			// the entry being written back this cycle is read stale by the memory
			fwd_line_s1   <= mem_we && (s1_q.col == rd_a);
			fwd_right_s1  <= mem_we && (s1_q.col == rd_b);
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	assign rd_a = in_col_q;
	assign rd_b = col_inc[COL_W-1:0];

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_line_d_s1  <= wr_line;
			fwd_right_d_s1 <= wr_mid;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[s1_q.col]  <= wr_line;
			right_mem[s1_q.col] <= wr_mid;
		end
		if (acc) begin
			line_rd_s1  <= line_mem[rd_a];
			right_rd_s1 <= right_mem[rd_b];
		end
	end

	// neighbourhood and kernel
	assign line_s1      = fwd_line_s1 ? fwd_line_d_s1 : line_rd_s1;
	assign upper_s1     = line_s1[2*PIX_W-1:PIX_W];
	assign ctr_s1       = line_s1[PIX_W-1:0];
	assign right_raw_s1 = fwd_right_s1 ? fwd_right_d_s1 : right_rd_s1;
	assign top_s1       = s1_q.top_ctr  ? ctr_s1 : upper_s1;
	assign left_s1      = s1_q.left_ctr ? ctr_s1 : left_q;
	assign right_s1     = s1_q.right_ok ? right_raw_s1 : ctr_s1;
	assign bot_s1       = s1_q.drain    ? ctr_s1 : s1_q.px;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_s1[i*CH_W +: CH_W] = sharpen_chan(top_s1[i*CH_W +: CH_W],
				left_s1[i*CH_W +: CH_W], ctr_s1[i*CH_W +: CH_W],
				right_s1[i*CH_W +: CH_W], bot_s1[i*CH_W +: CH_W]);
		end
	end

	// write back: upper takes the old middle, middle takes the new pixel (kept on a drain)
	assign mem_we  = s1_valid_q && s1_adv;
	assign wr_mid  = s1_q.drain ? ctr_s1 : s1_q.px;
	assign wr_line = {ctr_s1, wr_mid};

	// left neighbour of the next column is this column's old middle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			left_q <= ctr_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_s1;
			out_last_q <= s1_q.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_c) |=> (in_col_q == '0 && in_row_q == '0 && !pending_q))
		else $error("frame end did not clear the counters");

	a_res_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit_c) |=> (s1_valid_q && s1_q.res))
		else $error("item with a result missing from read stage");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s1_valid_q && s1_q.res))
		else $error("output became valid without a result in the read stage");
`endif

endmodule

`default_nettype wire
